FILE: hdl/gpio_edge_interrupt_controller_macros.svh
// Assertion macros shared by the GPIO edge interrupt controller checkers.
`ifndef GPIO_EDGE_INTERRUPT_CONTROLLER_MACROS_SVH
`define GPIO_EDGE_INTERRUPT_CONTROLLER_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define GEIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define GEIC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: hdl/geic_pkg.sv
// Package with types and constants of the GPIO edge interrupt controller.
`timescale 1ns / 1ps

package geic_pkg;

    localparam int PIN_COUNT = 32;
    localparam int DATA_W    = 32;
    localparam int OFF_W     = 5;

    localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_WRITE     = 2'd1,
        KIND_PIN_SET   = 2'd2,
        KIND_PIN_CLEAR = 2'd3
    } t_kind;

    localparam logic [OFF_W-1:0] OFF_OUT_EN    = 5'd0;
    localparam logic [OFF_W-1:0] OFF_PINS      = 5'd1;
    localparam logic [OFF_W-1:0] OFF_SET       = 5'd2;
    localparam logic [OFF_W-1:0] OFF_CLEAR     = 5'd3;
    localparam logic [OFF_W-1:0] OFF_EDGE_DET  = 5'd4;
    localparam logic [OFF_W-1:0] OFF_FALL_EN   = 5'd5;
    localparam logic [OFF_W-1:0] OFF_RISE_EN   = 5'd6;
    localparam logic [OFF_W-1:0] OFF_IRQ_EN    = 5'd7;
    localparam logic [OFF_W-1:0] OFF_IRQ_STAT  = 5'd8;
    localparam logic [OFF_W-1:0] OFF_IRQ_ACK   = 5'd9;
    localparam logic [OFF_W-1:0] OFF_CAPT_EN   = 5'd12;
    localparam logic [OFF_W-1:0] OFF_TCAPT_EN  = 5'd13;
    localparam logic [OFF_W-1:0] OFF_IN_EN     = 5'd16;
    localparam logic [OFF_W-1:0] OFF_SPARE     = 5'd18;

    typedef struct packed {
        t_kind              kind;
        logic [OFF_W-1:0]   reg_offset;
        logic [DATA_W-1:0]  wdata;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic               irq_line;
        logic               bad_access;
    } t_out_item;

endpackage

FILE: hdl/geic_regs.sv
// Register file, edge detection and read decode of the GPIO controller.
`timescale 1ns / 1ps

module geic_regs
    import geic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [DATA_W-1:0] r_pins, r_out_en, r_in_en, r_rise_en, r_fall_en;
    logic [DATA_W-1:0] r_irq_en, r_irq_stat, r_spare;
    logic [DATA_W-1:0] n_pins, n_out_en, n_in_en, n_rise_en, n_fall_en;
    logic [DATA_W-1:0] n_irq_en, n_irq_stat, n_spare;
    logic [DATA_W-1:0] hi_mask, lo_mask, ack_mask, rising, falling;
    logic [DATA_W-1:0] rd;
    logic              bad;

    always_comb begin
        n_out_en  = r_out_en;
        n_in_en   = r_in_en;
        n_rise_en = r_rise_en;
        n_fall_en = r_fall_en;
        n_irq_en  = r_irq_en;
        n_spare   = r_spare;
        hi_mask   = '0;
        lo_mask   = '0;
        ack_mask  = '0;
        rd        = '0;
        bad       = 1'b0;
        case (i_item.kind)
            KIND_READ: begin
                case (i_item.reg_offset)
                    OFF_OUT_EN:   rd = r_out_en;
                    OFF_PINS:     rd = r_pins;
                    OFF_IRQ_EN:   rd = r_irq_en;
                    OFF_IRQ_STAT: rd = r_irq_stat;
                    OFF_IN_EN:    rd = r_in_en;
                    OFF_SPARE:    rd = r_spare;
                    default:      bad = 1'b1;
                endcase
            end
            KIND_WRITE: begin
                case (i_item.reg_offset)
                    OFF_OUT_EN:   n_out_en = i_item.wdata;
                    OFF_SET:      hi_mask = i_item.wdata;
                    OFF_CLEAR:    lo_mask = i_item.wdata;
                    OFF_EDGE_DET: ;
                    OFF_FALL_EN:  n_fall_en = i_item.wdata;
                    OFF_RISE_EN:  n_rise_en = i_item.wdata;
                    OFF_IRQ_EN:   n_irq_en = i_item.wdata;
                    OFF_IRQ_ACK:  ack_mask = i_item.wdata;
                    OFF_CAPT_EN:  ;
                    OFF_TCAPT_EN: ;
                    OFF_IN_EN:    n_in_en = i_item.wdata;
                    OFF_SPARE:    n_spare = i_item.wdata;
                    default:      bad = 1'b1;
                endcase
            end
            KIND_PIN_SET:   hi_mask = i_item.wdata;
            KIND_PIN_CLEAR: lo_mask = i_item.wdata;
            default: ;
        endcase
        rising     = hi_mask & PIN_MASK & ~r_pins;
        falling    = lo_mask & PIN_MASK & r_pins;
        n_pins     = (r_pins | rising) & ~falling;
        n_irq_stat = (r_irq_stat | (rising & r_rise_en) | (falling & r_fall_en)) & ~ack_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins     <= '0;
            r_out_en   <= '0;
            r_in_en    <= '0;
            r_rise_en  <= '0;
            r_fall_en  <= '0;
            r_irq_en   <= '0;
            r_irq_stat <= '0;
            r_spare    <= '0;
        end else if (i_accept) begin
            r_pins     <= n_pins;
            r_out_en   <= n_out_en;
            r_in_en    <= n_in_en;
            r_rise_en  <= n_rise_en;
            r_fall_en  <= n_fall_en;
            r_irq_en   <= n_irq_en;
            r_irq_stat <= n_irq_stat;
            r_spare    <= n_spare;
        end
    end

    assign o_result.rdata      = rd;
    assign o_result.irq_line   = |(n_irq_en & n_irq_stat);
    assign o_result.bad_access = bad;

endmodule

FILE: hdl/gpio_edge_interrupt_controller.sv
// Top level of the 32-pin GPIO controller with edge interrupts.
`timescale 1ns / 1ps

// Each transfer on the input channel is a bus read, a bus write or an external
// pin set or clear mask, and yields exactly one result transfer carrying the read
// data, the interrupt line level after the transfer and an unmapped-access flag.
// Its result is registered at the edge that accepts it, in the output register
// if that is free or being emptied, else in the second buffer entry. A two-entry
// output buffer lets a new transfer be accepted every cycle, and input ready drops
// only when both entries hold results that have not yet been taken.
module gpio_edge_interrupt_controller
    import geic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_out_item result;
    logic      in_fire, out_fire;
    logic      r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    t_out_item r_out_item, n_out_item, r_skid_item, n_skid_item;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    geic_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_fire),
        .i_item   (i_in_item),
        .o_result (result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (out_fire) begin
            if (r_skid_valid) begin
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                n_out_item  = result;
                n_out_valid = 1'b1;
            end else begin
                n_skid_item  = result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hdl/geic_checker.sv
// Port-level checker for the GPIO edge interrupt controller and its binding.
`timescale 1ns / 1ps
`include "gpio_edge_interrupt_controller_macros.svh"

module geic_checker
    import geic_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `GEIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_item), "Result changed or vanished while stalled")
    `GEIC_ASSERT(a_bad_no_data, i_clk, i_rst_n,
        !o_out_valid || !o_out_item.bad_access || o_out_item.rdata == '0,
        "Unmapped access returned non-zero data")
    `GEIC_ASSERT_NEXT(a_accept_shows, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid,
        o_out_valid, "Accepted transfer produced no result")
    `GEIC_ASSERT(a_full_only_stalled, i_clk, i_rst_n, o_in_ready || o_out_valid,
        "Input stalled with no result pending")

endmodule

bind gpio_edge_interrupt_controller geic_checker u_geic_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the GPIO controller with edge interrupts.
`timescale 1ns / 1ps

module testbench;
    import geic_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    logic [DATA_W-1:0] pins_q = '0;
    logic [DATA_W-1:0] out_en_q = '0;
    logic [DATA_W-1:0] in_en_q = '0;
    logic [DATA_W-1:0] rise_en_q = '0;
    logic [DATA_W-1:0] fall_en_q = '0;
    logic [DATA_W-1:0] irq_en_q = '0;
    logic [DATA_W-1:0] irq_stat_q = '0;
    logic [DATA_W-1:0] spare_q = '0;

    t_out_item pending_gpio_results[$];
    t_out_item want_result;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    int        hold_off_request = 0;
    bit        tx_idle_enable = 1'b1;
    bit        rx_idle_enable = 1'b1;

    gpio_edge_interrupt_controller uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic void raise_pins(input logic [DATA_W-1:0] mask);
        logic [DATA_W-1:0] rising;
        rising = mask & PIN_MASK & ~pins_q;
        pins_q = pins_q | rising;
        irq_stat_q = irq_stat_q | (rising & rise_en_q);
    endfunction

    function automatic void lower_pins(input logic [DATA_W-1:0] mask);
        logic [DATA_W-1:0] falling;
        falling = mask & PIN_MASK & pins_q;
        pins_q = pins_q & ~falling;
        irq_stat_q = irq_stat_q | (falling & fall_en_q);
    endfunction

    function automatic t_out_item apply_gpio_access(input t_in_item item);
        t_out_item res;
        res = '0;
        case (item.kind)
            KIND_READ: begin
                case (item.reg_offset)
                    OFF_OUT_EN:   res.rdata = out_en_q;
                    OFF_PINS:     res.rdata = pins_q;
                    OFF_IRQ_EN:   res.rdata = irq_en_q;
                    OFF_IRQ_STAT: res.rdata = irq_stat_q;
                    OFF_IN_EN:    res.rdata = in_en_q;
                    OFF_SPARE:    res.rdata = spare_q;
                    default:      res.bad_access = 1'b1;
                endcase
            end
            KIND_WRITE: begin
                case (item.reg_offset)
                    OFF_OUT_EN:   out_en_q = item.wdata;
                    OFF_SET:      raise_pins(item.wdata);
                    OFF_CLEAR:    lower_pins(item.wdata);
                    OFF_EDGE_DET, OFF_CAPT_EN, OFF_TCAPT_EN: ;
                    OFF_FALL_EN:  fall_en_q = item.wdata;
                    OFF_RISE_EN:  rise_en_q = item.wdata;
                    OFF_IRQ_EN:   irq_en_q = item.wdata;
                    OFF_IRQ_ACK:  irq_stat_q = irq_stat_q & ~item.wdata;
                    OFF_IN_EN:    in_en_q = item.wdata;
                    OFF_SPARE:    spare_q = item.wdata;
                    default:      res.bad_access = 1'b1;
                endcase
            end
            KIND_PIN_SET: raise_pins(item.wdata);
            default:      lower_pins(item.wdata);
        endcase
        res.irq_line = |(irq_en_q & irq_stat_q);
        return res;
    endfunction

    function automatic t_in_item make_item(input t_kind kind, input logic [OFF_W-1:0] reg_off,
                                           input logic [DATA_W-1:0] data);
        t_in_item item;
        item.kind       = kind;
        item.reg_offset = reg_off;
        item.wdata      = data;
        return item;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] writable_offset();
        case ($urandom_range(0, 13))
            0:       return OFF_OUT_EN;
            1, 2:    return OFF_SET;
            3, 4:    return OFF_CLEAR;
            5:       return OFF_EDGE_DET;
            6:       return OFF_FALL_EN;
            7:       return OFF_RISE_EN;
            8:       return OFF_IRQ_EN;
            9, 10:   return OFF_IRQ_ACK;
            11:      return $urandom_range(0, 1) ? OFF_CAPT_EN : OFF_TCAPT_EN;
            12:      return OFF_IN_EN;
            default: return OFF_SPARE;
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] readable_offset();
        case ($urandom_range(0, 5))
            0:       return OFF_OUT_EN;
            1:       return OFF_PINS;
            2:       return OFF_IRQ_EN;
            3:       return OFF_IRQ_STAT;
            4:       return OFF_IN_EN;
            default: return OFF_SPARE;
        endcase
    endfunction

    task automatic send_item(input t_in_item item);
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_gpio_results.push_back(apply_gpio_access(item));
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_idle_enable && $urandom_range(0, 5) == 0) begin
            pause_input($urandom_range(1, 13));
        end
        if (pick < 30) begin
            send_item(make_item($urandom_range(0, 1) ? KIND_PIN_SET : KIND_PIN_CLEAR,
                                OFF_W'($urandom), random_word()));
        end else if (pick < 60) begin
            send_item(make_item(KIND_WRITE, writable_offset(), random_word()));
        end else if (pick < 88) begin
            send_item(make_item(KIND_READ, readable_offset(), random_word()));
        end else begin
            send_item(make_item(t_kind'($urandom_range(0, 3)), OFF_W'($urandom), random_word()));
        end
    endtask

    task automatic test_register_map();
        send_item(make_item(KIND_WRITE, OFF_OUT_EN, '1));
        send_item(make_item(KIND_READ, OFF_OUT_EN, '0));
        send_item(make_item(KIND_WRITE, OFF_IN_EN, '1));
        send_item(make_item(KIND_READ, OFF_IN_EN, '0));
        send_item(make_item(KIND_WRITE, OFF_SPARE, '1));
        send_item(make_item(KIND_READ, OFF_SPARE, '1));
        send_item(make_item(KIND_WRITE, OFF_EDGE_DET, '1));
        send_item(make_item(KIND_WRITE, OFF_CAPT_EN, '1));
        send_item(make_item(KIND_WRITE, OFF_TCAPT_EN, '1));
        send_item(make_item(KIND_READ, OFF_SET, '0));
        send_item(make_item(KIND_WRITE, OFF_PINS, '1));
        send_item(make_item(KIND_READ, 5'd31, '0));
        send_item(make_item(KIND_WRITE, 5'd19, '1));
    endtask

    task automatic test_edge_capture();
        send_item(make_item(KIND_WRITE, OFF_RISE_EN, '1));
        send_item(make_item(KIND_WRITE, OFF_FALL_EN, 32'h0000_FFFF));
        send_item(make_item(KIND_WRITE, OFF_IRQ_EN, '1));
        send_item(make_item(KIND_PIN_SET, 5'd31, '1));
        send_item(make_item(KIND_READ, OFF_IRQ_STAT, '0));
        send_item(make_item(KIND_WRITE, OFF_IRQ_ACK, '1));
        send_item(make_item(KIND_PIN_SET, OFF_OUT_EN, '1));
        send_item(make_item(KIND_PIN_CLEAR, OFF_PINS, '1));
        send_item(make_item(KIND_PIN_CLEAR, OFF_PINS, '1));
        send_item(make_item(KIND_WRITE, OFF_SET, 32'h8000_0001));
        send_item(make_item(KIND_WRITE, OFF_CLEAR, '1));
        send_item(make_item(KIND_READ, OFF_PINS, '0));
        send_item(make_item(KIND_WRITE, OFF_IRQ_EN, '0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_backpressure(input int count);
        hold_off_request = HOLD_CYCLES;
        repeat (count) send_item(make_item(t_kind'($urandom_range(0, 3)),
                                           readable_offset(), random_word()));
    endtask

    task automatic test_streaming(input int count);
        tx_idle_enable = 1'b0;
        rx_idle_enable = 1'b0;
        repeat (count) send_random_item();
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_gpio_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                error_count++;
            end else begin
                want_result = pending_gpio_results.pop_front();
                if (out_item.rdata !== want_result.rdata) begin
                    $display("%0t: rdata mismatch, expected %h, actual %h",
                             $time, want_result.rdata, out_item.rdata);
                    error_count++;
                end
                if (out_item.irq_line !== want_result.irq_line) begin
                    $display("%0t: irq_line mismatch, expected %b, actual %b",
                             $time, want_result.irq_line, out_item.irq_line);
                    error_count++;
                end
                if (out_item.bad_access !== want_result.bad_access) begin
                    $display("%0t: bad_access mismatch, expected %b, actual %b",
                             $time, want_result.bad_access, out_item.bad_access);
                    error_count++;
                end
            end
        end
        if (stall_left == 0 && rx_idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13);
        end
        if (hold_off_request != 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_map();
        test_edge_capture();
        test_random_traffic(1500);
        test_backpressure(30);
        test_random_traffic(20);
        test_streaming(380);
        in_valid <= 1'b0;
        while (pending_gpio_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
